// File: hdl/tdps_pkg.sv
// ----------------------------------------------------------------------------
// tdps_pkg
// Shared types, constants and the set point scaling table for the
// table driven position sequencer.
// ----------------------------------------------------------------------------
package tdps_pkg;

   localparam int STEP_COUNT_DEF = 10;

   // Field widths fixed by the interface
   localparam int STEP_W     = 4;
   localparam int SETPT_W    = 8;
   localparam int DUR_W      = 8;
   localparam int BOUND_W    = 16;
   localparam int TEMP_W     = 16;
   localparam int VOLT_W     = 8;
   localparam int CNT_W      = 16;
   localparam int POS_W      = 10;
   localparam int LIMIT_W    = 12;

   // Set point scaling: position = setpoint * SCALE_NUM / SCALE_DEN
   localparam int SCALE_NUM  = 10000;
   localparam int SCALE_DEN  = 978;
   localparam int TICK_UNIT  = 10;
   localparam logic [7:0] POS_HI_MASK = 8'h03;
   localparam logic [7:0] POS_RESET   = 8'hFF;

   typedef enum logic [1:0] {
      RULE_TIME = 2'd0,
      RULE_TEMP = 2'd1,
      RULE_VOLT = 2'd2
   } rule_type;

   typedef enum logic {
      MODE_TICK = 1'b0,
      MODE_LOAD = 1'b1
   } mode_type;

   // One stored step, already in the form the tick path needs
   typedef struct packed {
      logic [POS_W-1:0]          pos;
      logic [1:0]                rule;
      logic                      last;
      logic [LIMIT_W-1:0]        limit;
      logic signed [BOUND_W-1:0] low;
      logic signed [BOUND_W-1:0] high;
   } entry_type;

   typedef struct packed {
      logic [7:0]        pos_lo;
      logic [7:0]        pos_hi;
      logic              written;
      logic [STEP_W-1:0] step;
   } result_type;

   typedef logic [POS_W-1:0] scale_lut_type [256];

   function automatic scale_lut_type build_scale_lut();
      scale_lut_type lut;
      for (int i = 0; i < 256; i++) begin
         lut[i] = POS_W'((i * SCALE_NUM) / SCALE_DEN);
      end
      return lut;
   endfunction

   localparam scale_lut_type POS_SCALE = build_scale_lut();

endpackage

// File: hdl/tdps_step_table.sv
// ----------------------------------------------------------------------------
// tdps_step_table
// Step table storage. A load writes the scaled entry at its own index and its
// next id into the jump slot of the entry before it, so a tick reads
// everything it needs at a single index.
// ----------------------------------------------------------------------------
module tdps_step_table
   import tdps_pkg::*;
#(
   parameter int STEP_COUNT = STEP_COUNT_DEF
) (
   input  logic                      clock,
   input  logic                      load_en,
   input  logic [STEP_W-1:0]         load_index,
   input  logic [STEP_W-1:0]         load_next_id,
   input  logic [SETPT_W-1:0]        load_position,
   input  logic [1:0]                load_rule,
   input  logic                      load_last,
   input  logic [DUR_W-1:0]          load_duration,
   input  logic signed [BOUND_W-1:0] load_low,
   input  logic signed [BOUND_W-1:0] load_high,
   input  logic [STEP_W-1:0]         rd_index,
   output entry_type                 rd_entry,
   output logic [STEP_W-1:0]         rd_jump_id
);

   localparam int IDX_W = (STEP_COUNT > 1) ? $clog2(STEP_COUNT) : 1;
   localparam logic [STEP_W:0] COUNT_EXT = (STEP_W + 1)'(STEP_COUNT);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STEP_COUNT - 1);

   entry_type         entry_mem [STEP_COUNT];
   logic [STEP_W-1:0] jump_mem  [STEP_COUNT];

   logic              in_range;
   logic [IDX_W-1:0]  wr_idx;
   logic [IDX_W-1:0]  jump_idx;
   entry_type         wr_entry;

   assign in_range = {1'b0, load_index} < COUNT_EXT;
   assign wr_idx   = load_index[IDX_W-1:0];
   // the slot before entry zero is the last one
   assign jump_idx = (wr_idx == '0) ? LAST_IDX : wr_idx - 1'b1;

   always_comb begin
      wr_entry.pos   = POS_SCALE[load_position];
      wr_entry.rule  = load_rule;
      wr_entry.last  = load_last;
      wr_entry.limit = LIMIT_W'(load_duration) * LIMIT_W'(TICK_UNIT);
      wr_entry.low   = load_low;
      wr_entry.high  = load_high;
   end

   always_ff @(posedge clock) begin
      if (load_en && in_range) begin
         entry_mem[wr_idx] <= wr_entry;
         jump_mem[jump_idx] <= load_next_id;
      end
   end

   assign rd_entry   = entry_mem[rd_index[IDX_W-1:0]];
   assign rd_jump_id = jump_mem[rd_index[IDX_W-1:0]];

endmodule

// File: hdl/tdps_step_engine.sv
// ----------------------------------------------------------------------------
// tdps_step_engine
// Sequencer state: step id, tick counter and position registers. Evaluates
// one tick against the current table entry and produces the result.
// ----------------------------------------------------------------------------
module tdps_step_engine
   import tdps_pkg::*;
#(
   parameter int STEP_COUNT = STEP_COUNT_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     fire,
   input  logic                     mode,
   input  logic                     seq_enable,
   input  logic signed [TEMP_W-1:0] temp_sample,
   input  logic signed [VOLT_W-1:0] volt_sample,
   input  entry_type                entry,
   input  logic [STEP_W-1:0]        jump_id,
   output logic [STEP_W-1:0]        step_id,
   output result_type               result
);

   localparam logic [STEP_W:0] COUNT_EXT = (STEP_W + 1)'(STEP_COUNT);

   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [7:0]        pos_lo_ff, pos_lo_in;
   logic [7:0]        pos_hi_ff, pos_hi_in;

   logic                      is_tick;
   logic                      run;
   logic signed [BOUND_W-1:0] volt_ext;
   logic                      temp_ok;
   logic                      volt_ok;
   logic                      in_window;
   logic                      wr_pos;
   logic                      jump;
   logic [CNT_W-1:0]          cnt_inc;
   logic                      expire;

   assign is_tick  = (mode == MODE_TICK);
   assign run      = is_tick && seq_enable && ({1'b0, step_ff} < COUNT_EXT);
   assign volt_ext = BOUND_W'(volt_sample);
   assign temp_ok  = (temp_sample >= entry.low) && (temp_sample <= entry.high);
   assign volt_ok  = (volt_ext >= entry.low) && (volt_ext <= entry.high);

   always_comb begin
      case (entry.rule)
         RULE_TEMP: in_window = temp_ok;
         RULE_VOLT: in_window = volt_ok;
         default:   in_window = 1'b0;
      endcase
   end

   assign wr_pos  = run && ((entry.rule == RULE_TIME) || in_window);
   assign jump    = run && in_window;
   // a window jump clears the counter before it advances
   assign cnt_inc = (jump ? '0 : cnt_ff) + 1'b1;
   assign expire  = cnt_inc >= CNT_W'(entry.limit);

   always_comb begin
      step_in   = step_ff;
      cnt_in    = cnt_ff;
      pos_lo_in = pos_lo_ff;
      pos_hi_in = pos_hi_ff;
      if (is_tick && !seq_enable) begin
         step_in = '0;
      end else if (run) begin
         if (expire) begin
            step_in = entry.last ? '0 : jump_id;
            cnt_in  = '0;
         end else begin
            if (jump) begin
               step_in = jump_id;
            end
            cnt_in = cnt_inc;
         end
      end
      if (wr_pos) begin
         pos_lo_in = entry.pos[7:0];
         pos_hi_in = 8'(entry.pos >> 8) & POS_HI_MASK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= '0;
         cnt_ff    <= '0;
         pos_lo_ff <= POS_RESET;
         pos_hi_ff <= POS_RESET;
      end else if (fire) begin
         step_ff   <= step_in;
         cnt_ff    <= cnt_in;
         pos_lo_ff <= pos_lo_in;
         pos_hi_ff <= pos_hi_in;
      end
   end

   assign step_id = step_ff;

   always_comb begin
      result.pos_lo  = pos_lo_in;
      result.pos_hi  = pos_hi_in;
      result.written = wr_pos;
      result.step    = step_in;
   end

endmodule

// File: hdl/table_driven_position_sequencer.sv
// ----------------------------------------------------------------------------
// table_driven_position_sequencer
// Runs a loadable step table of valve positions, one tick per request.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_ready  mode, entry fields, samples
//   rsp_      out        rsp_valid / rsp_ready  position bytes, written, step
//   csr_      in         csr_wr_en              csr_wr_data (seq_enable)
//
// One request per clock sustained while responses are taken; a response is
// valid after its request has passed the input register, then the result
// register. The table lookup, window compare and counter update sit between
// those two registers; sequencer state updates as the item leaves the input
// register, so each item sees the state left by the one before.
// A stalled response holds the input register; ready falls only when both
// registers are full. Reset clears step, counter and enable and sets both
// position bytes to 0xFF; table contents are undefined until loaded.
// ----------------------------------------------------------------------------
module table_driven_position_sequencer
   import tdps_pkg::*;
#(
   parameter int STEP_COUNT = STEP_COUNT_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_mode,
   input  logic [STEP_W-1:0]         req_entry_index,
   input  logic [STEP_W-1:0]         req_entry_next_id,
   input  logic [SETPT_W-1:0]        req_entry_position,
   input  logic [1:0]                req_entry_rule,
   input  logic                      req_entry_last,
   input  logic [DUR_W-1:0]          req_entry_duration,
   input  logic signed [BOUND_W-1:0] req_entry_low,
   input  logic signed [BOUND_W-1:0] req_entry_high,
   input  logic signed [TEMP_W-1:0]  req_temp_sample,
   input  logic signed [VOLT_W-1:0]  req_volt_sample,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [7:0]                rsp_position_low,
   output logic [7:0]                rsp_position_high,
   output logic                      rsp_position_written,
   output logic [STEP_W-1:0]         rsp_current_step,
   input  logic                      csr_wr_en,
   input  logic                      csr_wr_data
);

   logic seq_enable_ff;

   // input register
   logic                      in_valid_ff;
   logic                      mode_ff;
   logic [STEP_W-1:0]         index_ff;
   logic [STEP_W-1:0]         next_id_ff;
   logic [SETPT_W-1:0]        position_ff;
   logic [1:0]                rule_ff;
   logic                      last_ff;
   logic [DUR_W-1:0]          duration_ff;
   logic signed [BOUND_W-1:0] low_ff;
   logic signed [BOUND_W-1:0] high_ff;
   logic signed [TEMP_W-1:0]  temp_ff;
   logic signed [VOLT_W-1:0]  volt_ff;

   // result register
   logic       rsp_valid_ff;
   result_type rsp_ff;

   logic              req_xfer;
   logic              fire;
   logic              load_en;
   logic [STEP_W-1:0] step_id;
   entry_type         cur_entry;
   logic [STEP_W-1:0] jump_id;
   result_type        result;

   // advance when the result register is free or drains this cycle
   assign fire      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;
   assign req_xfer  = req_valid && req_ready;
   assign load_en   = fire && (mode_ff == MODE_LOAD);

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_enable_ff <= 1'b0;
      end else if (csr_wr_en) begin
         seq_enable_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         mode_ff     <= req_mode;
         index_ff    <= req_entry_index;
         next_id_ff  <= req_entry_next_id;
         position_ff <= req_entry_position;
         rule_ff     <= req_entry_rule;
         last_ff     <= req_entry_last;
         duration_ff <= req_entry_duration;
         low_ff      <= req_entry_low;
         high_ff     <= req_entry_high;
         temp_ff     <= req_temp_sample;
         volt_ff     <= req_volt_sample;
      end
   end

   tdps_step_table #(
      .STEP_COUNT (STEP_COUNT)
   ) u_table (
      .clock         (clock),
      .load_en       (load_en),
      .load_index    (index_ff),
      .load_next_id  (next_id_ff),
      .load_position (position_ff),
      .load_rule     (rule_ff),
      .load_last     (last_ff),
      .load_duration (duration_ff),
      .load_low      (low_ff),
      .load_high     (high_ff),
      .rd_index      (step_id),
      .rd_entry      (cur_entry),
      .rd_jump_id    (jump_id)
   );

   tdps_step_engine #(
      .STEP_COUNT (STEP_COUNT)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .mode        (mode_ff),
      .seq_enable  (seq_enable_ff),
      .temp_sample (temp_ff),
      .volt_sample (volt_ff),
      .entry       (cur_entry),
      .jump_id     (jump_id),
      .step_id     (step_id),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_position_low     = rsp_ff.pos_lo;
   assign rsp_position_high    = rsp_ff.pos_hi;
   assign rsp_position_written = rsp_ff.written;
   assign rsp_current_step     = rsp_ff.step;

endmodule

// File: bench/tb_table_driven_position_sequencer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_table_driven_position_sequencer
// Loads the step table, then runs directed ticks and random loads and ticks
// through the sequencer in phases, with the enable register changed between
// phases. A local copy of the sequencer state predicts every response, and
// the responses are checked in order. Both channels idle at random, and the
// response side stalls for long stretches to back up the request side.
// ----------------------------------------------------------------------------
module tb_table_driven_position_sequencer;
   import tdps_pkg::*;

   localparam int STEPS = STEP_COUNT_DEF;
   localparam logic [1:0] RULE_NONE = 2'd3;
   localparam int PHASES = 16;
   localparam int PHASE_ITEMS = 100;

   typedef struct {
      mode_type                  mode;
      logic [STEP_W-1:0]         slot;
      logic [STEP_W-1:0]         next_id;
      logic [SETPT_W-1:0]        setpt;
      logic [1:0]                rule;
      logic                      last;
      logic [DUR_W-1:0]          duration;
      logic signed [BOUND_W-1:0] low;
      logic signed [BOUND_W-1:0] high;
      logic signed [TEMP_W-1:0]  temp;
      logic signed [VOLT_W-1:0]  volt;
   } seq_item;

   typedef struct {
      logic [STEP_W-1:0]         next_id;
      logic [SETPT_W-1:0]        setpt;
      logic [1:0]                rule;
      logic                      last;
      logic [DUR_W-1:0]          duration;
      logic signed [BOUND_W-1:0] low;
      logic signed [BOUND_W-1:0] high;
   } step_entry;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_mode = 1'b0;
   logic [STEP_W-1:0]         req_entry_index = '0;
   logic [STEP_W-1:0]         req_entry_next_id = '0;
   logic [SETPT_W-1:0]        req_entry_position = '0;
   logic [1:0]                req_entry_rule = '0;
   logic                      req_entry_last = 1'b0;
   logic [DUR_W-1:0]          req_entry_duration = '0;
   logic signed [BOUND_W-1:0] req_entry_low = '0;
   logic signed [BOUND_W-1:0] req_entry_high = '0;
   logic signed [TEMP_W-1:0]  req_temp_sample = '0;
   logic signed [VOLT_W-1:0]  req_volt_sample = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [7:0]                rsp_position_low;
   logic [7:0]                rsp_position_high;
   logic                      rsp_position_written;
   logic [STEP_W-1:0]         rsp_current_step;
   logic                      csr_wr_en = 1'b0;
   logic                      csr_wr_data = 1'b0;

   // sequencer state as predicted
   step_entry         steps [STEPS];
   logic [STEP_W-1:0] step_now = '0;
   logic [CNT_W-1:0]  ticks = '0;
   logic [7:0]        pos_lo = POS_RESET;
   logic [7:0]        pos_hi = POS_RESET;
   logic              seq_on = 1'b0;

   seq_item    pending_items[$];
   result_type expected_results[$];
   seq_item    on_offer;
   int         in_flight = 0;
   int         send_wait = 0;
   int         req_burst = 0;
   int         rsp_burst = 0;
   int         hold_left = 0;
   int         long_holds = 0;
   int         checked_count = 0;
   int         error_count = 0;

   table_driven_position_sequencer #(.STEP_COUNT(STEPS)) u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_mode             (req_mode),
      .req_entry_index      (req_entry_index),
      .req_entry_next_id    (req_entry_next_id),
      .req_entry_position   (req_entry_position),
      .req_entry_rule       (req_entry_rule),
      .req_entry_last       (req_entry_last),
      .req_entry_duration   (req_entry_duration),
      .req_entry_low        (req_entry_low),
      .req_entry_high       (req_entry_high),
      .req_temp_sample      (req_temp_sample),
      .req_volt_sample      (req_volt_sample),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_position_low     (rsp_position_low),
      .rsp_position_high    (rsp_position_high),
      .rsp_position_written (rsp_position_written),
      .rsp_current_step     (rsp_current_step),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data)
   );

   always #6 clock = ~clock;

   // Apply one item to the predicted state and return the response it gives.
   task automatic advance_sequencer(input seq_item it, output result_type res);
      step_entry   cur;
      int unsigned follow;
      int          scaled;
      int          sample;
      bit          hit;
      bit          wr;
      wr = 1'b0;
      hit = 1'b0;
      if (it.mode == MODE_LOAD) begin
         if (it.slot < STEPS) begin
            steps[it.slot] = '{it.next_id, it.setpt, it.rule, it.last, it.duration,
                               it.low, it.high};
         end
      end else if (!seq_on) begin
         step_now = '0;
      end else if (step_now < STEPS) begin
         cur = steps[step_now];
         follow = (int'(step_now) + 1) % STEPS;
         scaled = (int'(cur.setpt) * SCALE_NUM) / SCALE_DEN;
         sample = (cur.rule == RULE_VOLT) ? int'(it.volt) : int'(it.temp);
         case (cur.rule)
            RULE_TIME: wr = 1'b1;
            RULE_TEMP, RULE_VOLT: begin
               hit = (sample >= int'(cur.low)) && (sample <= int'(cur.high));
            end
            default: ;
         endcase
         if (hit) begin
            wr = 1'b1;
            step_now = steps[follow].next_id;
            ticks = '0;
         end
         if (wr) begin
            pos_lo = scaled[7:0];
            pos_hi = {6'b0, scaled[9:8]};
         end
         ticks = ticks + 1'b1;
         if (int'(ticks) >= int'(cur.duration) * TICK_UNIT) begin
            step_now = cur.last ? '0 : steps[follow].next_id;
            ticks = '0;
         end
      end
      res.pos_lo = pos_lo;
      res.pos_hi = pos_hi;
      res.written = wr;
      res.step = step_now;
   endtask

   // Often no gap, else mostly short ones, a few long ones, or a run with none.
   function automatic int idle_length(inout int burst_left);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if (r < 3) begin
         burst_left = $urandom_range(30, 80);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic report_failure(input string msg);
      error_count++;
      if (error_count <= 10) $display("ERROR: %s", msg);
   endtask

   // request driver
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            advance_sequencer(on_offer, want);
            expected_results.push_back(want);
            in_flight--;
         end
         if (!req_valid || req_ready) begin
            if (send_wait > 0) begin
               send_wait--;
               req_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               on_offer = pending_items.pop_front();
               in_flight++;
               req_mode <= on_offer.mode;
               req_entry_index <= on_offer.slot;
               req_entry_next_id <= on_offer.next_id;
               req_entry_position <= on_offer.setpt;
               req_entry_rule <= on_offer.rule;
               req_entry_last <= on_offer.last;
               req_entry_duration <= on_offer.duration;
               req_entry_low <= on_offer.low;
               req_entry_high <= on_offer.high;
               req_temp_sample <= on_offer.temp;
               req_volt_sample <= on_offer.volt;
               req_valid <= 1'b1;
               send_wait = idle_length(req_burst);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and receiver
   always @(posedge clock) begin
      result_type want;
      result_type got;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.pos_lo = rsp_position_low;
            got.pos_hi = rsp_position_high;
            got.written = rsp_position_written;
            got.step = rsp_current_step;
            if (expected_results.size() == 0) begin
               report_failure($sformatf("response %0d with nothing outstanding", checked_count));
            end else begin
               want = expected_results.pop_front();
               if (got.pos_lo !== want.pos_lo || got.pos_hi !== want.pos_hi ||
                   got.written !== want.written || got.step !== want.step) begin
                  report_failure($sformatf(
                     "response %0d: exp lo=%0d hi=%0d wr=%0d step=%0d, got lo=%0d hi=%0d wr=%0d step=%0d",
                     checked_count, want.pos_lo, want.pos_hi, want.written, want.step,
                     got.pos_lo, got.pos_hi, got.written, got.step));
               end
            end
            checked_count++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (long_holds < 2 && checked_count >= 300 * (long_holds + 1) &&
                      pending_items.size() > 40) begin
            // hold off long enough for the request side to back up
            long_holds++;
            hold_left = 150;
            rsp_ready <= 1'b0;
         end else begin
            hold_left = idle_length(rsp_burst);
            if (hold_left == 0) begin
               rsp_ready <= 1'b1;
            end else begin
               hold_left--;
               rsp_ready <= 1'b0;
            end
         end
      end
   end

   task automatic load_step(input int slot, input int next_id, input int setpt,
                            input logic [1:0] rule, input bit last, input int duration,
                            input int low, input int high);
      seq_item it;
      it = '{MODE_LOAD, STEP_W'(slot), STEP_W'(next_id), SETPT_W'(setpt), rule, last,
             DUR_W'(duration), BOUND_W'(low), BOUND_W'(high), '0, '0};
      pending_items.push_back(it);
   endtask

   task automatic tick(input int temp, input int volt);
      seq_item it;
      it = '{MODE_TICK, '0, '0, '0, RULE_TIME, 1'b0, '0, '0, '0,
             TEMP_W'(temp), VOLT_W'(volt)};
      pending_items.push_back(it);
   endtask

   function automatic seq_item random_item();
      seq_item     it;
      int unsigned r;
      it.mode = ($urandom_range(0, 99) < 22) ? MODE_LOAD : MODE_TICK;
      it.slot = ($urandom_range(0, 9) == 0) ? STEP_W'($urandom_range(STEPS, 15))
                                            : STEP_W'($urandom_range(0, STEPS - 1));
      it.next_id = ($urandom_range(0, 19) == 0) ? STEP_W'($urandom_range(STEPS, 15))
                                                : STEP_W'($urandom_range(0, STEPS - 1));
      it.setpt = SETPT_W'($urandom);
      r = $urandom_range(0, 9);
      if (r == 0) it.rule = RULE_NONE;
      else if (r < 4) it.rule = RULE_TIME;
      else if (r < 7) it.rule = RULE_TEMP;
      else it.rule = RULE_VOLT;
      it.last = ($urandom_range(0, 5) == 0);
      r = $urandom_range(0, 9);
      if (r < 6) it.duration = DUR_W'($urandom_range(0, 2));
      else if (r < 9) it.duration = DUR_W'($urandom_range(3, 10));
      else it.duration = DUR_W'($urandom);
      // keep most windows near the sample range so that they are hit often
      if ($urandom_range(0, 9) == 0) begin
         it.low = BOUND_W'($urandom);
         it.high = BOUND_W'($urandom);
      end else begin
         it.low = BOUND_W'(int'($urandom_range(0, 250)) - 150);
         it.high = BOUND_W'(int'(it.low) + int'($urandom_range(0, 200)) - 20);
      end
      r = $urandom_range(0, 9);
      if (r < 7) it.temp = TEMP_W'(int'($urandom_range(0, 300)) - 150);
      else if (r < 9) it.temp = TEMP_W'($urandom);
      else it.temp = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      it.volt = VOLT_W'($urandom);
      return it;
   endfunction

   task automatic wait_drained();
      do @(posedge clock);
      while (pending_items.size() != 0 || in_flight != 0 || expected_results.size() != 0);
   endtask

   task automatic write_enable(input bit value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      seq_on = value;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // fill every table slot before any enabled tick can read one
      load_step(0, 0, 0, RULE_TIME, 1'b0, 0, -32768, 32767);
      load_step(1, 1, 255, RULE_TEMP, 1'b0, 255, -32768, 32767);
      load_step(2, 2, 128, RULE_VOLT, 1'b0, 1, -128, 127);
      load_step(3, 3, 97, RULE_NONE, 1'b0, 0, 0, 0);
      load_step(4, 4, 200, RULE_TEMP, 1'b0, 0, 100, 50);
      load_step(5, 5, 1, RULE_TIME, 1'b1, 0, 32767, -32768);
      load_step(6, 15, 64, RULE_VOLT, 1'b0, 2, -10, 10);
      load_step(7, 7, 254, RULE_TEMP, 1'b1, 3, -32768, -32768);
      load_step(8, 8, 10, RULE_TIME, 1'b0, 1, 32767, 32767);
      load_step(9, 9, 170, RULE_VOLT, 1'b1, 0, -128, -128);
      load_step(10, 12, 255, RULE_TIME, 1'b1, 255, -1, -1);
      load_step(15, 15, 255, RULE_NONE, 1'b1, 255, 32767, -32768);
      tick(32767, 127);
      tick(-32768, -128);
      wait_drained();
      write_enable(1'b1);

      tick(0, 0);
      tick(32767, 127);
      tick(-32768, -128);
      tick(0, 0);
      tick(100, 5);
      tick(-1, -1);
      tick(32767, 0);
      tick(-32768, 127);
      tick(1, -128);
      tick(0, 1);
      wait_drained();

      for (int p = 0; p < PHASES; p++) begin
         write_enable((p % 4) != 2);
         for (int i = 0; i < PHASE_ITEMS; i++) pending_items.push_back(random_item());
         wait_drained();
      end

      repeat (10) @(posedge clock);
      if (expected_results.size() != 0) report_failure("responses still outstanding at end");
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
